@@ sv/btpl_pkg.sv @@
// Shared types and constants for the bracket table lookup block.
// Holds field widths, operation and register codes, and the structs
// passed between the scan controller, the entry RAM and the MAC unit.
package btpl_pkg;

  // Table and number formats
  localparam int unsigned TABLE_DEPTH        = 64;
  localparam int unsigned AMOUNT_WIDTH       = 48;
  localparam int unsigned RATE_WIDTH         = 32;
  localparam int unsigned RATE_FRACTION_BITS = 24;

  // Field widths fixed by the transaction format
  localparam int unsigned ENTRY_IDX_W = 6;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned SEL_W       = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 7;

  // Derived widths: RAM address and scan counter (holds the depth itself)
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Output select codes; both codes with the top bit set pick the computed value
  localparam logic [SEL_W-1:0] SEL_BASE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_RATE = 2'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUSIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 1'b1;

  // One bracket entry as stored in the RAM
  typedef struct packed {
    logic [AMOUNT_WIDTH-1:0] limit;
    logic [AMOUNT_WIDTH-1:0] base;
    logic [RATE_WIDTH-1:0]   rate;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Request into the multiply-add unit
  typedef struct packed {
    logic                    start;
    logic [AMOUNT_WIDTH-1:0] query;
    logic [AMOUNT_WIDTH-1:0] prev;
    logic [AMOUNT_WIDTH-1:0] base;
    logic [RATE_WIDTH-1:0]   rate;
  } mac_req_t;

  // Response from the multiply-add unit
  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic [AMOUNT_WIDTH-1:0] value;
  } mac_rsp_t;

endpackage

@@ sv/btpl_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module btpl_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered; rdata_o holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/btpl_mac.sv @@
// Multi-cycle multiply-add: base + round((query - prev) * rate), saturated.
// Depends on btpl_pkg for widths and the request/response structs.
module btpl_mac import btpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  localparam int unsigned AW   = AMOUNT_WIDTH;
  localparam int unsigned RW   = RATE_WIDTH;
  localparam int unsigned F    = RATE_FRACTION_BITS;
  localparam int unsigned H    = (AW + 1) / 2;        // lower slice of the excess
  localparam int unsigned PW   = AW + RW;             // full product width
  localparam int unsigned MW   = PW + 1 - F;          // rounded magnitude width
  localparam int unsigned SW   = MW + 2;              // signed sum width
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (F - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MLO  = 3'd1;
  localparam logic [2:0] ST_MHI  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_BASE = 3'd4;
  localparam logic [2:0] ST_SAT  = 3'd5;

  logic [2:0]      step_q;
  logic            done_q;

  logic [AW:0]     diff;
  logic [AW:0]     dmag_full;
  logic [RW-1:0]   rmag;

  logic [AW-1:0]   dmag_q;
  logic [RW-1:0]   rmag_q;
  logic            neg_q;
  logic [AW-1:0]   base_q;

  logic [H-1:0]    mul_a;
  logic [H+RW-1:0] mul_p;
  logic [H+RW-1:0] plo_q;
  logic [H+RW-1:0] phi_q;
  logic [PW:0]     prod_d;
  logic [PW:0]     prod_q;
  logic [SW-1:0]   base_ext;
  logic [SW-1:0]   mag_ext;
  logic [SW-1:0]   sum_d;
  logic [SW-1:0]   sum_q;
  logic            fits;
  logic            sat_q;
  logic [AW-1:0]   value_q;

  // Form excess and rate magnitudes
  assign diff      = {req_i.query[AW-1], req_i.query} - {req_i.prev[AW-1], req_i.prev};
  assign dmag_full = diff[AW] ? ((~diff) + 1'b1) : diff;
  assign rmag      = req_i.rate[RW-1] ? ((~req_i.rate) + 1'b1) : req_i.rate;

  // Share one multiplier between the two slices of the excess
  assign mul_a = (step_q == ST_MLO) ? dmag_q[H-1:0] : H'(dmag_q[AW-1:H]);
  assign mul_p = mul_a * rmag_q;

  // Recombine the partial products and round half away from zero
  assign prod_d = (PW + 1)'(plo_q) + ((PW + 1)'(phi_q) << H) + HALF;

  // Apply the sign and add the base at full width
  assign base_ext = SW'($signed(base_q));
  assign mag_ext  = SW'(prod_q[PW:F]);
  assign sum_d    = neg_q ? (base_ext - mag_ext) : (base_ext + mag_ext);

  // The sum fits when every bit above the amount sign matches it
  assign fits = (sum_q[SW-1:AW-1] == '0) || (sum_q[SW-1:AW-1] == '1);

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (step_q)
        ST_IDLE: begin
          if (req_i.start) begin
            step_q <= ST_MLO;
          end
        end
        ST_MLO:  step_q <= ST_MHI;
        ST_MHI:  step_q <= ST_ADD;
        ST_ADD:  step_q <= ST_BASE;
        ST_BASE: step_q <= ST_SAT;
        ST_SAT: begin
          step_q <= ST_IDLE;
          done_q <= 1'b1;
        end
        default: step_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (step_q == ST_IDLE && req_i.start) begin
      dmag_q <= dmag_full[AW-1:0];
      rmag_q <= rmag;
      neg_q  <= diff[AW] ^ req_i.rate[RW-1];
      base_q <= req_i.base;
    end
    if (step_q == ST_MLO) begin
      plo_q <= mul_p;
    end
    if (step_q == ST_MHI) begin
      phi_q <= mul_p;
    end
    if (step_q == ST_ADD) begin
      prod_q <= prod_d;
    end
    if (step_q == ST_BASE) begin
      sum_q <= sum_d;
    end
    if (step_q == ST_SAT) begin
      sat_q <= !fits;
      if (fits) begin
        value_q <= sum_q[AW-1:0];
      end else if (sum_q[SW-1]) begin
        value_q <= {1'b1, {(AW - 1){1'b0}}};
      end else begin
        value_q <= {1'b0, {(AW - 1){1'b1}}};
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.sat   = sat_q;
  assign rsp_o.value = value_q;

endmodule

@@ sv/btpl_scan.sv @@
// Scan controller: writes entries, walks the entry RAM for a lookup and
// forms the result. Depends on btpl_pkg; drives btpl_ram and btpl_mac.
module btpl_scan import btpl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    op_i,
  input  logic [ENTRY_IDX_W-1:0]  entry_index_i,
  input  logic [AMOUNT_WIDTH-1:0] entry_limit_i,
  input  logic [AMOUNT_WIDTH-1:0] entry_base_i,
  input  logic [RATE_WIDTH-1:0]   entry_rate_i,
  input  logic [AMOUNT_WIDTH-1:0] query_value_i,
  input  logic [SEL_W-1:0]        output_select_i,
  input  logic                    inclusive_i,
  input  logic [COUNT_W-1:0]      count_i,
  output logic                    busy_o,
  output logic                    ram_we_o,
  output logic [IDX_W-1:0]        ram_waddr_o,
  output entry_t                  ram_wdata_o,
  output logic                    ram_re_o,
  output logic [IDX_W-1:0]        ram_raddr_o,
  input  entry_t                  ram_rdata_i,
  output mac_req_t                mac_req_o,
  input  mac_rsp_t                mac_rsp_i,
  output logic                    done_o,
  output logic [AMOUNT_WIDTH-1:0] result_value_o,
  output logic                    found_o,
  output logic                    saturated_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MAC  = 2'd2;

  logic [1:0]              state_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        n_q;
  logic [CNT_W-1:0]        n_d;
  logic [AMOUNT_WIDTH-1:0] query_q;
  logic [SEL_W-1:0]        sel_q;
  logic [AMOUNT_WIDTH-1:0] prev_q;
  logic [AMOUNT_WIDTH-1:0] res_q;
  logic                    found_q;
  logic                    sat_q;

  logic                    accept;
  logic                    lookup;
  logic                    hit;
  logic                    last;
  logic [AMOUNT_WIDTH-1:0] pick;

  assign accept = start_i && (state_q == S_IDLE);
  assign lookup = accept && (op_i == OP_LOOKUP);
  assign busy_o = (state_q != S_IDLE);

  // Clamp the entry count to the table depth
  assign n_d = (count_i > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_i);

  // Entry writes happen only while idle, so reads and writes never overlap
  assign ram_we_o    = accept && (op_i == OP_WRITE) && (entry_index_i < TABLE_DEPTH);
  assign ram_waddr_o = IDX_W'(entry_index_i);
  assign ram_wdata_o = '{limit: entry_limit_i, base: entry_base_i, rate: entry_rate_i};

  // Fetch entry zero on accept, then run one entry ahead of the compare
  assign ram_re_o    = lookup || (state_q == S_SCAN);
  assign ram_raddr_o = (state_q == S_SCAN) ? IDX_W'(cnt_q[IDX_W-1:0] + 1'b1) : '0;

  // Compare the fetched limit with the query
  assign hit = ($signed(query_q) < $signed(ram_rdata_i.limit)) ||
               (inclusive_i && (query_q == ram_rdata_i.limit));
  assign last = (CNT_W'(cnt_q + 1'b1) == n_q);

  assign pick = (sel_q == SEL_RATE) ? AMOUNT_WIDTH'($signed(ram_rdata_i.rate))
                                    : ram_rdata_i.base;

  // Hand the matched bracket to the multiply-add unit
  assign mac_req_o.start = (state_q == S_SCAN) && hit && sel_q[1];
  assign mac_req_o.query = query_q;
  assign mac_req_o.prev  = prev_q;
  assign mac_req_o.base  = ram_rdata_i.base;
  assign mac_req_o.rate  = ram_rdata_i.rate;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (lookup) begin
            if (n_d == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (sel_q[1]) begin
              state_q <= S_MAC;
            end else begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end else if (last) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_MAC: begin
          if (mac_rsp_i.done) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Transaction and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (lookup) begin
          query_q <= query_value_i;
          sel_q   <= output_select_i;
          n_q     <= n_d;
          cnt_q   <= '0;
          prev_q  <= '0;
          res_q   <= '0;
          found_q <= 1'b0;
          sat_q   <= 1'b0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_q <= 1'b1;
          res_q   <= pick;
        end else begin
          prev_q <= ram_rdata_i.limit;
          cnt_q  <= CNT_W'(cnt_q + 1'b1);
        end
      end
      S_MAC: begin
        if (mac_rsp_i.done) begin
          res_q <= mac_rsp_i.value;
          sat_q <= mac_rsp_i.sat;
        end
      end
      default: ;
    endcase
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign found_o        = found_q;
  assign saturated_o    = sat_q;

endmodule

@@ sv/bracket_table_piecewise_linear.sv @@
// Top level of the bracket table lookup block: configuration registers,
// entry RAM, scan controller and multiply-add unit. Depends on btpl_pkg.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ------------------------------------------
//  request   start_i, busy_o           op_i, entry_index_i, entry_limit_i,
//                                      entry_base_i, entry_rate_i, query_value_i,
//                                      output_select_i
//  result    done_o (one-cycle strobe) result_value_o, found_o, saturated_o
//  config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A write transaction gives no result. A lookup that matches entry i
// strobes done_o straight from the scan for base or rate, and after the
// five MAC steps for the computed value; a miss strobes once the scan has
// passed n entries, n being the clamped entry count. The entry RAM read,
// one entry per cycle, sets the scan. Reset clears the configuration and
// control state; entries are undefined until written. The receiver cannot
// stall; busy_o holds off new requests.
module bracket_table_piecewise_linear import btpl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    op_i,
  input  logic [ENTRY_IDX_W-1:0]  entry_index_i,
  input  logic [AMOUNT_WIDTH-1:0] entry_limit_i,
  input  logic [AMOUNT_WIDTH-1:0] entry_base_i,
  input  logic [RATE_WIDTH-1:0]   entry_rate_i,
  input  logic [AMOUNT_WIDTH-1:0] query_value_i,
  input  logic [SEL_W-1:0]        output_select_i,
  output logic                    done_o,
  output logic [AMOUNT_WIDTH-1:0] result_value_o,
  output logic                    found_o,
  output logic                    saturated_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  logic               inclusive_q;
  logic [COUNT_W-1:0] count_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  mac_req_t           mac_req;
  mac_rsp_t           mac_rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inclusive_q <= 1'b0;
      count_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INCLUSIVE: inclusive_q <= cfg_data_i[0];
        CFG_COUNT:     count_q     <= COUNT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  btpl_ram #(
    .Depth (TABLE_DEPTH),
    .Width (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  btpl_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .op_i            (op_i),
    .entry_index_i   (entry_index_i),
    .entry_limit_i   (entry_limit_i),
    .entry_base_i    (entry_base_i),
    .entry_rate_i    (entry_rate_i),
    .query_value_i   (query_value_i),
    .output_select_i (output_select_i),
    .inclusive_i     (inclusive_q),
    .count_i         (count_q),
    .busy_o          (busy_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (entry_t'(ram_rdata)),
    .mac_req_o       (mac_req),
    .mac_rsp_i       (mac_rsp),
    .done_o          (done_o),
    .result_value_o  (result_value_o),
    .found_o         (found_o),
    .saturated_o     (saturated_o)
  );

  btpl_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  // A result is only strobed once the controller is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while a lookup is still running");

  // Clipping only happens on a matched bracket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |-> found_o)
    else $error("saturated result without a matching bracket");

  // An entry write never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (op_i == OP_WRITE)) |=> !done_o)
    else $error("entry write produced a result");

endmodule
